// ===== rtl/core/jse_pkg.sv =====
package jse_pkg;

	// most bytes one code unit can produce (a \uXXXX escape)
	localparam int MAX_BYTES = 6;
	localparam int CNT_W = $clog2(MAX_BYTES + 1);

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// characters used by the escapes
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_string;
	} unit_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} text_t;

	// one classified code unit: its escaped bytes, first byte in element 0
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
	} entry_t;

endpackage

// ===== rtl/core/jse_front.sv =====
module jse_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           unit_valid,
	output logic           unit_ready,
	input  jse_pkg::unit_t unit_data,
	input  logic           q_full,
	output logic           push,
	output jse_pkg::entry_t push_data
);

	logic        utf16_q;
	logic        pending_q;
	logic [9:0]  held_q;

	logic        accept;
	logic [15:0] v;
	logic [7:0]  esc_c;
	logic        esc_short;
	logic        esc_long;
	logic        is_high;
	logic [20:0] cp;
	logic [15:0] u;

	function automatic logic [7:0] hex_digit(input logic [3:0] d);
		logic [7:0] r;
		if (d < 4'd10) begin
			r = 8'h30 + {4'h0, d};
		end else begin
			r = 8'h37 + {4'h0, d};
		end
		return r;
	endfunction

	assign unit_ready = !q_full;
	assign accept     = unit_valid && unit_ready;
	assign u          = unit_data.code_unit;

	always_comb begin
		v = utf16_q ? u : {8'h00, u[7:0]};
		esc_short = 1'b1;
		unique case (v)
			16'h0008: esc_c = 8'h62;
			16'h000C: esc_c = 8'h66;
			16'h000A: esc_c = 8'h6E;
			16'h000D: esc_c = 8'h72;
			16'h0009: esc_c = 8'h74;
			16'h0022: esc_c = jse_pkg::CH_QUOTE;
			16'h005C: esc_c = jse_pkg::CH_BSLASH;
			default: begin
				esc_c = 8'h00;
				esc_short = 1'b0;
			end
		endcase
		esc_long = !esc_short && (v < 16'd32);
		is_high  = utf16_q && (u >= 16'hD800) && (u <= 16'hDBFF);
		cp       = 21'h10000 + {1'b0, held_q, u[9:0]};
	end

	always_comb begin
		push_data = '0;
		priority if (utf16_q && pending_q) begin
			// joined surrogate pair, always four bytes
			push_data.bytes[0] = {5'b11110, cp[20:18]};
			push_data.bytes[1] = {2'b10, cp[17:12]};
			push_data.bytes[2] = {2'b10, cp[11:6]};
			push_data.bytes[3] = {2'b10, cp[5:0]};
			push_data.count    = jse_pkg::CNT_W'(4);
		end else if (esc_short) begin
			push_data.bytes[0] = jse_pkg::CH_BSLASH;
			push_data.bytes[1] = esc_c;
			push_data.count    = jse_pkg::CNT_W'(2);
		end else if (esc_long) begin
			push_data.bytes[0] = jse_pkg::CH_BSLASH;
			push_data.bytes[1] = jse_pkg::CH_U;
			push_data.bytes[2] = hex_digit(v[15:12]);
			push_data.bytes[3] = hex_digit(v[11:8]);
			push_data.bytes[4] = hex_digit(v[7:4]);
			push_data.bytes[5] = hex_digit(v[3:0]);
			push_data.count    = jse_pkg::CNT_W'(6);
		end else if (!utf16_q) begin
			push_data.bytes[0] = v[7:0];
			push_data.count    = jse_pkg::CNT_W'(1);
		end else if (is_high) begin
			// held or dropped, nothing to send
			push_data.count = '0;
		end else if (u < 16'h0080) begin
			push_data.bytes[0] = u[7:0];
			push_data.count    = jse_pkg::CNT_W'(1);
		end else if (u < 16'h0800) begin
			push_data.bytes[0] = {3'b110, u[10:6]};
			push_data.bytes[1] = {2'b10, u[5:0]};
			push_data.count    = jse_pkg::CNT_W'(2);
		end else begin
			push_data.bytes[0] = {4'b1110, u[15:12]};
			push_data.bytes[1] = {2'b10, u[11:6]};
			push_data.bytes[2] = {2'b10, u[5:0]};
			push_data.count    = jse_pkg::CNT_W'(3);
		end
	end

	assign push = accept && (push_data.count != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			utf16_q   <= 1'b1;
			pending_q <= 1'b0;
			held_q    <= '0;
		end else begin
			if (cfg_we) begin
				utf16_q <= cfg_wdata;
			end
			if (accept) begin
				if (!utf16_q || pending_q) begin
					pending_q <= 1'b0;
				end else if (is_high && !unit_data.end_of_string) begin
					held_q    <= u[9:0];
					pending_q <= 1'b1;
				end
				if (unit_data.end_of_string) begin
					pending_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/jse_queue.sv =====
module jse_queue #(
	parameter int DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jse_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output jse_pkg::entry_t pop_data,
	output logic            empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	jse_pkg::entry_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");

endmodule

// ===== rtl/core/jse_back.sv =====
module jse_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  jse_pkg::entry_t q_data,
	output logic            pop,
	output logic            text_valid,
	input  logic            text_ready,
	output jse_pkg::text_t  text_data
);

	localparam int CW = jse_pkg::CNT_W;

	jse_pkg::entry_t cur_q;
	logic [CW-1:0]   idx_q;
	logic            active_q;
	logic            text_valid_q;
	jse_pkg::text_t  text_q;

	logic            load;
	logic            have;
	logic [7:0]      nxt_byte;
	logic            nxt_last;

	assign load = !text_valid_q || text_ready;
	assign have = active_q || !q_empty;

	always_comb begin
		pop = 1'b0;
		if (active_q) begin
			nxt_byte = cur_q.bytes[idx_q];
			nxt_last = (idx_q == cur_q.count - CW'(1));
		end else begin
			// first byte goes straight out of the queue head
			nxt_byte = q_data.bytes[0];
			nxt_last = (q_data.count == CW'(1));
			pop      = load && !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load && have) begin
			text_q.out_byte  <= nxt_byte;
			text_q.last_byte <= nxt_last;
		end
		if (pop && !nxt_last) begin
			cur_q <= q_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid_q <= 1'b0;
			active_q     <= 1'b0;
			idx_q        <= '0;
		end else begin
			if (load) begin
				text_valid_q <= have;
			end
			if (load && active_q) begin
				if (nxt_last) begin
					active_q <= 1'b0;
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (pop && !nxt_last) begin
				active_q <= 1'b1;
				idx_q    <= CW'(1);
			end
		end
	end

	assign text_valid = text_valid_q;
	assign text_data  = text_q;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q != '0) && (idx_q < cur_q.count))
		else $error("byte index outside current entry");

	a_entry_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_data.count != '0) && (q_data.count <= CW'(jse_pkg::MAX_BYTES)))
		else $error("queue entry with bad byte count");

endmodule

// ===== rtl/core/json_string_escaper_utf8.sv =====
// json string escaper with utf-16 to utf-8 conversion
// unit channel (unit_valid/unit_ready/unit_data): one code unit of the string
//   per transaction, end_of_string set on the last unit
// text channel (text_valid/text_ready/text_data): one byte of escaped json
//   text per transaction, last_byte set on the final byte of each unit
// cfg_we/cfg_wdata: input_is_utf16 (1 = utf-16 units, 0 = raw bytes)
// the first byte of a unit reaches text_valid through the queue and then
//   the output register
// throughput: one output byte per cycle, set by the single output register,
//   while text_ready is high and entries are waiting; a unit yields 1 to 6
//   bytes, a held or dropped high surrogate yields nothing
// reset: utf-16 mode, no surrogate held, queue and output empty
// receiver stall: the output register holds its byte, the classifier keeps
//   accepting units into the queue until it is full, then unit_ready drops
module json_string_escaper_utf8 #(
	parameter int QUEUE_DEPTH = jse_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	input  logic           unit_valid,
	output logic           unit_ready,
	input  jse_pkg::unit_t unit_data,
	output logic           text_valid,
	input  logic           text_ready,
	output jse_pkg::text_t text_data
);

	// classified entries between front and back
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;
	jse_pkg::entry_t push_data;
	jse_pkg::entry_t pop_data;

	// front: config register, surrogate state, byte formation
	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.unit_valid(unit_valid),
		.unit_ready(unit_ready),
		.unit_data (unit_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	// short queue so that front and back stall independently
	jse_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (q_full),
		.pop      (pop),
		.pop_data (pop_data),
		.empty    (q_empty)
	);

	// back: serializes each entry one byte per cycle, while text_ready allows, into the output register
	jse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (pop_data),
		.pop       (pop),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_data (text_data)
	);

endmodule
